### src/ltp_pkg.sv
package ltp_pkg;

    // Default sizes of the parse table, the token alphabet and the return stack.
    localparam int ROWS_DEF        = 256;
    localparam int TOKENS_DEF      = 32;
    localparam int STACK_DEPTH_DEF = 64;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Walk limit register.
    localparam int              WALK_W         = 10;
    localparam logic [WALK_W-1:0] MAX_WALK_RESET = 10'd1023;

    // Command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TOKEN = 2'd2;

    // Status codes, also used as the stored verdict (zero means still parsing).
    localparam logic [1:0] STS_CONSUMED = 2'd0;
    localparam logic [1:0] STS_ACCEPTED = 2'd1;
    localparam logic [1:0] STS_REJECTED = 2'd2;
    localparam logic [1:0] STS_DONE     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  row_addr;
        logic [31:0] guide_mask;
        logic        has_next;
        logic [7:0]  next_row;
        logic        shifts;
        logic        has_push;
        logic [7:0]  push_row;
        logic        error_row;
        logic        end_row;
        logic [4:0]  token;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] current_row;
        logic [6:0] stack_depth;
    } t_out_item;

    // One parse table row as stored in the table memory.
    typedef struct packed {
        logic [31:0] guide_mask;
        logic        has_next;
        logic [7:0]  next_row;
        logic        shifts;
        logic        has_push;
        logic [7:0]  push_row;
        logic        error_row;
        logic        end_row;
    } t_row;

    // A classified item as it waits in the queue.
    typedef struct packed {
        logic [1:0] op;
        logic       wr_ok;
        logic [7:0] addr;
        t_row       row;
        logic [4:0] tok;
        logic       tok_ok;
    } t_job;

endpackage

### src/ltp_ram.sv
module ltp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ltp_front.sv
module ltp_front #(
    parameter int ROWS   = ltp_pkg::ROWS_DEF,
    parameter int TOKENS = ltp_pkg::TOKENS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ltp_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    output ltp_pkg::t_job     o_job,
    input  logic              i_pop
);

    localparam int QAW = $clog2(ltp_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(ltp_pkg::QUEUE_DEPTH + 1);

    ltp_pkg::t_job  r_q [ltp_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    ltp_pkg::t_job  job;
    logic           push;

    // Classify the incoming item: range checks are done here once.
    always_comb begin
        job.op              = i_in_item.command;
        job.wr_ok           = 32'(i_in_item.row_addr) < ROWS;
        job.addr            = i_in_item.row_addr;
        job.row.guide_mask  = i_in_item.guide_mask;
        job.row.has_next    = i_in_item.has_next;
        job.row.next_row    = i_in_item.next_row;
        job.row.shifts      = i_in_item.shifts;
        job.row.has_push    = i_in_item.has_push;
        job.row.push_row    = i_in_item.push_row;
        job.row.error_row   = i_in_item.error_row;
        job.row.end_row     = i_in_item.end_row;
        job.tok             = i_in_item.token;
        job.tok_ok          = 32'(i_in_item.token) < TOKENS;
    end

    assign o_in_stall = (r_count == QCW'(ltp_pkg::QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_job      = r_q[r_rd_ptr];

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + QAW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QAW'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ltp_pkg::QUEUE_DEPTH)
        else $error("job queue count exceeds its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("job queue popped while empty");

endmodule

### src/ltp_back.sv
module ltp_back #(
    parameter int ROWS        = ltp_pkg::ROWS_DEF,
    parameter int STACK_DEPTH = ltp_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  ltp_pkg::t_job              i_job,
    output logic                       o_q_pop,
    input  logic [ltp_pkg::WALK_W-1:0] i_max_walk,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output ltp_pkg::t_out_item         o_out_item
);

    localparam int ROW_AW  = $clog2(ROWS);
    localparam int SAW     = $clog2(STACK_DEPTH);
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int ROW_W   = $bits(ltp_pkg::t_row);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [7:0]                 r_ptr, n_ptr;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [1:0]                 r_verdict, n_verdict;
    logic [ltp_pkg::WALK_W-1:0] r_visits, n_visits;
    logic [4:0]                 r_tok, n_tok;
    logic                       r_tok_ok, n_tok_ok;
    logic                       r_out_valid, n_out_valid;
    ltp_pkg::t_out_item         r_out_item, n_out_item;

    logic                       tbl_we;
    logic [ROW_W-1:0]           tbl_rdata;
    ltp_pkg::t_row              row;
    logic                       stk_we;
    logic [7:0]                 stk_rdata;
    logic                       out_free;

    // Parse table and return stack memories.
    ltp_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (ROW_AW'(i_job.addr)),
        .i_wdata (i_job.row),
        .i_raddr (ROW_AW'(r_ptr)),
        .o_rdata (tbl_rdata)
    );

    ltp_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (SAW'(r_cnt)),
        .i_wdata (row.push_row),
        .i_raddr (SAW'(r_cnt - CW'(1))),
        .o_rdata (stk_rdata)
    );

    assign row      = ltp_pkg::t_row'(tbl_rdata);
    assign out_free = !r_out_valid || !i_out_stall;

    // Job sequencer and row walker.
    always_comb begin
        logic       fin;
        logic       hit;
        logic [1:0] res;
        logic [7:0] ptr_w;
        logic [CW-1:0] cnt_w;
        logic [ltp_pkg::WALK_W-1:0] vis_w;

        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_verdict   = r_verdict;
        n_visits    = r_visits;
        n_tok       = r_tok;
        n_tok_ok    = r_tok_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        tbl_we      = 1'b0;
        stk_we      = 1'b0;
        o_q_pop     = 1'b0;
        fin         = 1'b0;
        hit         = 1'b0;
        res         = ltp_pkg::STS_REJECTED;
        ptr_w       = r_ptr;
        cnt_w       = r_cnt;
        vis_w       = r_visits + ltp_pkg::WALK_W'(1);

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop                = 1'b1;
                    n_out_valid            = 1'b1;
                    n_out_item.status      = ltp_pkg::STS_DONE;
                    n_out_item.current_row = r_ptr;
                    n_out_item.stack_depth = 7'(r_cnt);
                    case (i_job.op)
                        ltp_pkg::CMD_WRITE: begin
                            tbl_we = i_job.wr_ok;
                        end
                        ltp_pkg::CMD_START: begin
                            n_ptr                  = '0;
                            n_cnt                  = '0;
                            n_verdict              = ltp_pkg::STS_CONSUMED;
                            n_out_item.current_row = '0;
                            n_out_item.stack_depth = '0;
                        end
                        ltp_pkg::CMD_TOKEN: begin
                            if (r_verdict != ltp_pkg::STS_CONSUMED) begin
                                n_out_item.status = r_verdict;
                            end else if (32'(r_ptr) >= ROWS) begin
                                n_verdict         = ltp_pkg::STS_REJECTED;
                                n_out_item.status = ltp_pkg::STS_REJECTED;
                            end else begin
                                // Start a walk; the result comes when it ends.
                                n_out_valid = 1'b0;
                                n_tok       = i_job.tok;
                                n_tok_ok    = i_job.tok_ok;
                                n_visits    = '0;
                                n_state     = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // Row and stack top are read this cycle.
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                hit = r_tok_ok && row.guide_mask[r_tok];
                if (row.end_row) begin
                    fin = 1'b1;
                    res = ltp_pkg::STS_ACCEPTED;
                end else if (hit) begin
                    if (row.has_push) begin
                        if (32'(r_cnt) >= STACK_DEPTH) begin
                            fin = 1'b1;
                        end else begin
                            stk_we = 1'b1;
                            cnt_w  = r_cnt + CW'(1);
                        end
                    end
                    if (!fin) begin
                        if (row.has_next) begin
                            ptr_w = row.next_row;
                        end else if (!row.error_row) begin
                            if (r_ptr == 8'hFF) begin
                                fin = 1'b1;
                            end else begin
                                ptr_w = r_ptr + 8'd1;
                            end
                        end else if (cnt_w == '0) begin
                            fin = 1'b1;
                        end else begin
                            // A row that pushes and pops returns to its own push row.
                            cnt_w = cnt_w - CW'(1);
                            ptr_w = row.has_push ? row.push_row : stk_rdata;
                        end
                    end
                end else if (row.error_row || r_ptr == 8'hFF) begin
                    fin = 1'b1;
                end else begin
                    ptr_w = r_ptr + 8'd1;
                end

                // End of walk on a shift row, the walk limit, or a bad next row.
                if (!fin) begin
                    if (row.shifts) begin
                        fin = 1'b1;
                        res = ltp_pkg::STS_CONSUMED;
                    end else if (vis_w >= i_max_walk) begin
                        fin = 1'b1;
                    end else if (32'(ptr_w) >= ROWS) begin
                        fin = 1'b1;
                    end
                end

                n_ptr    = ptr_w;
                n_cnt    = cnt_w;
                n_visits = vis_w;
                if (fin) begin
                    n_state                = ST_IDLE;
                    n_verdict              = res;
                    n_out_valid            = 1'b1;
                    n_out_item.status      = res;
                    n_out_item.current_row = ptr_w;
                    n_out_item.stack_depth = 7'(cnt_w);
                end else begin
                    n_state = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_verdict   <= ltp_pkg::STS_CONSUMED;
            r_visits    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_verdict   <= n_verdict;
            r_visits    <= n_visits;
            r_out_valid <= n_out_valid;
        end
    end

    // Token and result payload need no reset.
    always_ff @(posedge i_clk) begin
        r_tok      <= n_tok;
        r_tok_ok   <= n_tok_ok;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= STACK_DEPTH)
        else $error("return stack count exceeds its depth");

    a_fetch_row_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (32'(r_ptr) < ROWS))
        else $error("walk fetches a row outside the table");

    a_fetch_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |=> (r_state == ST_EXEC))
        else $error("row fetch not followed by its execution");

    a_walk_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_visits == '0 || r_visits < i_max_walk))
        else $error("walk continued past its row limit");

endmodule

### src/ll1_table_parser_step_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_item  (ltp_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_item (ltp_pkg::t_out_item)
// config    in         i_cfg_wr_en                i_cfg_wr_data (max_walk)
//
// Items pass a two-entry job queue; a write, start, unknown command or finished-parse
// token is then answered by the back end without a walk, its result registered as the
// back end pops it. A token walk alternates a fetch and an execute state for every
// table row visited, set by the registered read of the table memory for every row.
// Reset is synchronous and active low; the table and return stack are not cleared.
// The input stalls only when the queue is full; a stalled result holds the back end.
module ll1_table_parser_step_core #(
    parameter int ROWS        = ltp_pkg::ROWS_DEF,
    parameter int TOKENS      = ltp_pkg::TOKENS_DEF,
    parameter int STACK_DEPTH = ltp_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ltp_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ltp_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [ltp_pkg::WALK_W-1:0] i_cfg_wr_data
);

    logic [ltp_pkg::WALK_W-1:0] r_max_walk;
    logic                       q_valid;
    ltp_pkg::t_job              q_job;
    logic                       q_pop;

    // Walk limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_walk <= ltp_pkg::MAX_WALK_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_walk <= i_cfg_wr_data;
        end
    end

    ltp_front #(.ROWS(ROWS), .TOKENS(TOKENS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_job      (q_job),
        .i_pop      (q_pop)
    );

    ltp_back #(.ROWS(ROWS), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_q_pop     (q_pop),
        .i_max_walk  (r_max_walk),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

### dv/testbench.sv
module testbench;

    // Command code that the block answers without doing anything.
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Cycles in which neither side moves an item before the run is declared hung.
    localparam int QUIET_LIMIT = 10000;

    // Length of the long output hold-off used to back up the block.
    localparam int HOLD_CYCLES = 300;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    ltp_pkg::t_in_item  in_item       = '0;
    logic               out_stall     = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [ltp_pkg::WALK_W-1:0] cfg_wr_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    ltp_pkg::t_out_item o_out_item;

    // Items waiting to be driven, and the results the parser owes us.
    ltp_pkg::t_in_item  cmd_queue [$];
    ltp_pkg::t_out_item due_results [$];

    // Shadow parser state.
    ltp_pkg::t_row rows_mem [ltp_pkg::ROWS_DEF];
    logic [7:0]    ret_rows [ltp_pkg::STACK_DEPTH_DEF];
    int            ret_depth   = 0;
    logic [7:0]    cur_row     = '0;
    logic [1:0]    parse_state = ltp_pkg::STS_CONSUMED;   // Consumed doubles as still parsing.
    logic [ltp_pkg::WALK_W-1:0] walk_cap = ltp_pkg::MAX_WALK_RESET;

    // Traffic shaping knobs, set by the sequence and read by the drivers.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_done      = 0;
    int hold_left      = 0;

    int fails = 0;
    int quiet = 0;

    ll1_table_parser_step_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Walk the shadow table for one token and return the resulting status.
    function automatic logic [1:0] walk_rows(input logic [4:0] tok);
        int unsigned   visits;
        ltp_pkg::t_row r;
        visits = 0;
        while (1) begin
            r = rows_mem[cur_row];
            if (r.end_row) return ltp_pkg::STS_ACCEPTED;
            if (r.guide_mask[tok]) begin
                if (r.has_push) begin
                    if (ret_depth >= ltp_pkg::STACK_DEPTH_DEF) return ltp_pkg::STS_REJECTED;
                    ret_rows[ret_depth] = r.push_row;
                    ret_depth++;
                end
                if (r.has_next) begin
                    cur_row = r.next_row;
                end else if (!r.error_row) begin
                    if (cur_row == 8'hFF) return ltp_pkg::STS_REJECTED;
                    cur_row++;
                end else begin
                    if (ret_depth == 0) return ltp_pkg::STS_REJECTED;
                    ret_depth--;
                    cur_row = ret_rows[ret_depth];
                end
            end else begin
                if (r.error_row) return ltp_pkg::STS_REJECTED;
                if (cur_row == 8'hFF) return ltp_pkg::STS_REJECTED;
                cur_row++;
            end
            visits++;
            if (r.shifts) return ltp_pkg::STS_CONSUMED;
            if (visits >= walk_cap) return ltp_pkg::STS_REJECTED;
        end
        return ltp_pkg::STS_REJECTED;
    endfunction

    // Apply one accepted item to the shadow parser and return its result.
    function automatic ltp_pkg::t_out_item parse_item(input ltp_pkg::t_in_item it);
        ltp_pkg::t_out_item res;
        res.status = ltp_pkg::STS_DONE;
        case (it.command)
            ltp_pkg::CMD_WRITE: begin
                rows_mem[it.row_addr] = {it.guide_mask, it.has_next, it.next_row, it.shifts,
                                         it.has_push, it.push_row, it.error_row, it.end_row};
            end
            ltp_pkg::CMD_START: begin
                cur_row     = '0;
                ret_depth   = 0;
                parse_state = ltp_pkg::STS_CONSUMED;
            end
            ltp_pkg::CMD_TOKEN: begin
                if (parse_state == ltp_pkg::STS_CONSUMED) begin
                    res.status  = walk_rows(it.token);
                    parse_state = res.status;
                end else begin
                    res.status = parse_state;
                end
            end
            default: ;
        endcase
        res.current_row = cur_row;
        res.stack_depth = 7'(ret_depth);
        return res;
    endfunction

    // Item with every field random; callers overwrite what matters.
    function automatic ltp_pkg::t_in_item rand_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(ltp_pkg::t_in_item)-1:0];
    endfunction

    function automatic ltp_pkg::t_row mk_row(input logic [31:0] guide, input logic nxt_en,
                                             input logic [7:0] nxt, input logic shf,
                                             input logic psh_en, input logic [7:0] psh,
                                             input logic err, input logic fin);
        return {guide, nxt_en, nxt, shf, psh_en, psh, err, fin};
    endfunction

    // Random table row; the density selects how often a token hits the guide set.
    function automatic ltp_pkg::t_row rand_row(input int dense);
        ltp_pkg::t_row r;
        case (dense)
            0:       r.guide_mask = $urandom;
            1:       r.guide_mask = $urandom | $urandom;
            default: r.guide_mask = $urandom & $urandom;
        endcase
        r.has_next  = 1'($urandom_range(1));
        r.next_row  = 8'($urandom_range(255));
        r.shifts    = $urandom_range(99) < 55;
        r.has_push  = $urandom_range(99) < 25;
        r.push_row  = 8'($urandom_range(255));
        r.error_row = $urandom_range(99) < 20;
        r.end_row   = $urandom_range(99) < 5;
        return r;
    endfunction

    task automatic put_row(input logic [7:0] addr, input ltp_pkg::t_row r);
        ltp_pkg::t_in_item it;
        it = rand_item();
        it.command  = ltp_pkg::CMD_WRITE;
        it.row_addr = addr;
        {it.guide_mask, it.has_next, it.next_row, it.shifts,
         it.has_push, it.push_row, it.error_row, it.end_row} = r;
        cmd_queue.push_back(it);
    endtask

    task automatic put_cmd(input logic [1:0] cmd, input logic [4:0] tok);
        ltp_pkg::t_in_item it;
        it = rand_item();
        it.command = cmd;
        it.token   = tok;
        cmd_queue.push_back(it);
    endtask

    // Returns at a falling edge once every queued item has been answered.
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // Walk limit writes happen only with the parser idle.
    task automatic write_walk_cap(input logic [ltp_pkg::WALK_W-1:0] v);
        wait_drained();
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        walk_cap     = v;
        @(negedge clk);
    endtask

    // Reset, directed cases, random phases, then the verdict.
    initial begin
        int                         ph;
        int                         n;
        int                         len;
        int                         dense;
        logic [ltp_pkg::WALK_W-1:0] cap;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every row is written before any walk can reach it.
        for (int a = 0; a < ltp_pkg::ROWS_DEF; a++) put_row(8'(a), rand_row(1));

        // Accepting end row reached after one shift.
        put_row(8'd0, mk_row('1, 1'b1, 8'd1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0));
        put_row(8'd1, mk_row('0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1));
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd31);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd0);
        // Row 2 pushes and jumps to itself until the return stack overflows;
        // the token after that only repeats the stored verdict.
        put_row(8'd0, mk_row('1, 1'b1, 8'd2, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
        put_row(8'd2, mk_row('1, 1'b1, 8'd2, 1'b0, 1'b1, 8'hAA, 1'b0, 1'b0));
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd7);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd12);
        // Row 0 pushes row 3 and pops it back; row 3 then pops an empty stack.
        // A miss on the error row rejects as well.
        put_row(8'd0, mk_row(32'h1, 1'b0, 8'd0, 1'b1, 1'b1, 8'd3, 1'b1, 1'b0));
        put_row(8'd3, mk_row('1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0));
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd9);
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd1);
        // Advancing past the last row rejects.
        put_row(8'd0, mk_row('1, 1'b1, 8'hFF, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
        put_row(8'hFF, mk_row('0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd31);
        // A row looping on itself runs into the walk limit, first at its
        // reset value, then at one and at zero.
        put_row(8'd0, mk_row('1, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd3);
        write_walk_cap(10'd1);
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd3);
        write_walk_cap(10'd0);
        put_cmd(ltp_pkg::CMD_START, 5'd0);
        put_cmd(ltp_pkg::CMD_TOKEN, 5'd3);
        put_cmd(CMD_NONE, 5'd0);

        // Random parses: up to four rows rewritten, usually a start, then a run of mostly tokens.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       cap = 10'd1023;
                1:       cap = 10'd1;
                2:       cap = 10'($urandom_range(1022, 2));
                3:       cap = 10'd0;
                4:       cap = 10'd6;
                default: cap = 10'd1023;
            endcase
            write_walk_cap(cap);
            case (ph / 2)
                0: begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 83;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 35;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            n = 0;
            while (n < 200) begin
                dense = $urandom_range(2);
                len   = $urandom_range(4);
                n    += len;
                repeat (len)
                    put_row(8'($urandom_range(99) < 50 ? $urandom_range(15)
                                                       : $urandom_range(255)),
                            rand_row(dense));
                if ($urandom_range(9) != 0) begin
                    put_cmd(ltp_pkg::CMD_START, 5'd0);
                    n++;
                end
                len = $urandom_range(12, 1);
                n  += len;
                repeat (len) begin
                    case ($urandom_range(15))
                        0:       put_cmd(CMD_NONE, 5'($urandom_range(31)));
                        1:       put_row(8'($urandom_range(255)), rand_row(dense));
                        default: put_cmd(ltp_pkg::CMD_TOKEN, 5'($urandom_range(31)));
                    endcase
                end
            end
            // Back the parser up while the sender keeps offering items.
            if (ph == 4) hold_asks++;
        end

        wait_drained();
        repeat (60) @(negedge clk);
        if (fails == 0 && due_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Item driver: a stalled item holds until it is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= cmd_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side stall, with an occasional long hold-off.
    always @(posedge clk) begin
        if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= $urandom_range(99) < recv_stall_pct;
        end
    end

    // Check each result against the oldest expectation, then predict new items.
    always @(posedge clk) begin
        ltp_pkg::t_out_item want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result with nothing expected: %p", o_out_item);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (o_out_item.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, o_out_item.status);
                        fails++;
                    end
                    if (o_out_item.current_row !== want.current_row) begin
                        $error("current_row expected %0d got %0d",
                               want.current_row, o_out_item.current_row);
                        fails++;
                    end
                    if (o_out_item.stack_depth !== want.stack_depth) begin
                        $error("stack_depth expected %0d got %0d",
                               want.stack_depth, o_out_item.stack_depth);
                        fails++;
                    end
                end
            end
            if (in_valid && !o_in_stall) due_results.push_back(parse_item(in_item));
        end
    end

    // Hang detection: count cycles in which neither side moves an item.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

endmodule
